// ===== rtl/kho_pkg.sv =====
// ----------------------------------------------------------------------------
// kho_pkg
// Shared types and constants of the killer/history move orderer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kho_pkg;

  localparam int unsigned MoveW    = 16;
  localparam int unsigned ScoreW   = 21;
  localparam int unsigned HistN    = 4096;
  // killer table slots, one per ply; ply_index is taken modulo this, so keep it 2^n <= 128
  localparam int unsigned PlySlots = 128;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CUTOFF = 2'd2;
  localparam logic [1:0] REQ_CLEAR  = 2'd3;

  localparam logic [ScoreW-1:0] ScoreHash    = 21'd1000000;
  localparam logic [ScoreW-1:0] ScoreCapture = 21'd500000;
  localparam logic [ScoreW-1:0] ScoreKiller1 = 21'd200000;
  localparam logic [ScoreW-1:0] ScoreKiller2 = 21'd180000;
  localparam logic [ScoreW-1:0] ScorePromo   = 21'd250000;
  localparam logic [ScoreW-1:0] ScorePromoK  = 21'd1000;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] move_word;
    logic [15:0] hash_move;
    logic [6:0]  ply_index;
    logic [5:0]  search_depth;
    logic        first_of_list;
  } req_t;

  typedef struct packed {
    logic [15:0] ordered_move;
    logic [20:0] move_priority;
    logic        is_last;
    logic        list_empty;
  } rsp_t;

endpackage

// ===== rtl/killer_history_move_orderer.sv =====
// ----------------------------------------------------------------------------
// killer_history_move_orderer
// Scores loaded moves, keeps them sorted in memory, serves them in order, and
// updates killers and history on cutoffs.
// Usage: a transaction is taken when start_i is high and busy_o low. Only a
// read gives a result: rsp_o is valid for one cycle with rsp_valid_o high;
// the receiver cannot stall it.
// Read: memory read, then result out. Cutoff: read, then write back if quiet.
// Load: a linear search reads the list from the head down to the insertion
// point, then the shift walks back up from count to it; each way, every entry
// is read, then compared or written one place up.
// Clear: one history entry per cycle on the single port; killers too.
// After reset the block runs that same clearing pass (busy_o high) before the
// first transaction is taken.
// The list memory needs no clear: only written entries are ever read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module killer_history_move_orderer #(
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  kho_pkg::req_t req_i,
  output logic          busy_o,
  output logic          rsp_valid_o,
  output kho_pkg::rsp_t rsp_o
);
  import kho_pkg::*;

  localparam int unsigned LA = $clog2(LIST_DEPTH);
  localparam int unsigned CW = LA + 1;
  localparam int unsigned PA = $clog2(PlySlots);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_CLR    = 12'b000000000010,
    S_LRD    = 12'b000000000100,
    S_LSC    = 12'b000000001000,
    S_SRCH   = 12'b000000010000,
    S_SCHK   = 12'b000000100000,
    S_SHRD   = 12'b000001000000,
    S_SHWR   = 12'b000010000000,
    S_RRD    = 12'b000100000000,
    S_ROUT   = 12'b001000000000,
    S_CRD    = 12'b010000000000,
    S_CWR    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // memories
  logic [MoveW-1:0]  mem_mv [LIST_DEPTH];
  logic [ScoreW-1:0] mem_sc [LIST_DEPTH];
  logic [MoveW-1:0]  mem_k1 [PlySlots];
  logic [MoveW-1:0]  mem_k2 [PlySlots];
  logic [15:0]       mem_h  [HistN];

  logic [MoveW-1:0] rd_mv, rd_k1, rd_k2;
  logic [ScoreW-1:0] rd_sc;
  logic [15:0] rd_h;

  logic [LA-1:0] l_ra, l_wa;
  logic l_we;
  logic [MoveW-1:0] l_wmv;
  logic [ScoreW-1:0] l_wsc;
  logic [PA-1:0] k_a;
  logic k_we;
  logic [MoveW-1:0] k_w1, k_w2;
  logic [11:0] h_a;
  logic h_we;
  logic [15:0] h_w;

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      mem_mv[l_wa] <= l_wmv;
      mem_sc[l_wa] <= l_wsc;
    end
    rd_mv <= mem_mv[l_ra];
    rd_sc <= mem_sc[l_ra];
  end

  always_ff @(posedge clk_i) begin
    if (k_we) begin
      mem_k1[k_a] <= k_w1;
      mem_k2[k_a] <= k_w2;
    end
    rd_k1 <= mem_k1[k_a];
    rd_k2 <= mem_k2[k_a];
  end

  always_ff @(posedge clk_i) begin
    if (h_we) mem_h[h_a] <= h_w;
    rd_h <= mem_h[h_a];
  end

  req_t req_q;
  logic [CW-1:0] cnt_q, cnt_d, rpos_q, rpos_d, pos_q, pos_d;
  logic [11:0] clr_q, clr_d;
  logic [ScoreW-1:0] sc_q, sc_d;
  logic [ScoreW-1:0] part_q, part_d;
  logic [15:0] inc_q;
  logic rv_d, rv_q;
  rsp_t rsp_d, rsp_q;

  logic [2:0] promo;
  logic [PA-1:0] slot;
  logic quiet;
  assign promo = req_q.move_word[14:12];
  assign slot  = req_q.ply_index[PA-1:0];
  assign quiet = !req_q.move_word[15] && (promo == 3'd0);

  // depth^2*8 fits 16 bits (63^2*8 = 31752)
  always_ff @(posedge clk_i) begin
    inc_q <= {1'b0, 12'(req_q.search_depth * req_q.search_depth), 3'b000};
  end

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; rpos_d = rpos_q; pos_d = pos_q; clr_d = clr_q;
    sc_d = sc_q; part_d = part_q;
    rv_d = 1'b0; rsp_d = rsp_q;
    l_ra = pos_q[LA-1:0]; l_wa = pos_q[LA-1:0]; l_we = 1'b0;
    l_wmv = rd_mv; l_wsc = rd_sc;
    k_a = slot; k_we = 1'b0; k_w1 = '0; k_w2 = '0;
    h_a = req_q.move_word[11:0]; h_we = 1'b0; h_w = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_i.req_type)
            REQ_LOAD:   state_d = S_LRD;
            REQ_READ:   state_d = S_RRD;
            REQ_CUTOFF: state_d = S_CRD;
            default: begin
              clr_d = '0;
              state_d = S_CLR;
            end
          endcase
        end
      end
      S_CLR: begin
        h_a = clr_q; h_we = 1'b1; h_w = '0;
        k_a = clr_q[PA-1:0]; k_we = (clr_q < 12'(PlySlots));
        clr_d = clr_q + 12'd1;
        if (clr_q == 12'(HistN - 1)) state_d = S_IDLE;
      end
      S_LRD: begin
        // new list handled here; killer/history read issued
        if (req_q.first_of_list) begin
          cnt_d = '0; rpos_d = '0;
        end
        if (req_q.first_of_list || cnt_q < CW'(LIST_DEPTH)) begin
          part_d = '0;
          if (req_q.move_word == req_q.hash_move) part_d = ScoreHash;
          state_d = S_LSC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_LSC: begin
        sc_d = part_q;
        if (req_q.move_word[15]) sc_d = sc_d + ScoreCapture;
        else begin
          if (req_q.move_word == rd_k1) sc_d = sc_d + ScoreKiller1;
          else if (req_q.move_word == rd_k2) sc_d = sc_d + ScoreKiller2;
          sc_d = sc_d + ScoreW'(rd_h);
        end
        if (promo != 3'd0)
          sc_d = sc_d + ScorePromo + ScoreW'(promo) * ScorePromoK;
        pos_d = '0;
        state_d = S_SRCH;
      end
      S_SRCH: begin
        // linear search: read entry pos
        if (pos_q >= cnt_q) begin
          pos_d = cnt_q;
          state_d = S_SHRD;
        end else begin
          state_d = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rd_sc >= sc_q) begin
          pos_d = pos_q + CW'(1);
          l_ra = pos_d[LA-1:0];
          state_d = S_SRCH;
        end else begin
          pos_d = cnt_q;
          state_d = S_SHRD;
        end
      end
      S_SHRD: begin
        // pos_q walks down from count; read entry below
        l_ra = LA'(pos_q - CW'(1));
        if (pos_q == '0) begin
          l_wa = '0; l_we = 1'b1; l_wmv = req_q.move_word; l_wsc = sc_q;
          cnt_d = cnt_q + CW'(1);
          state_d = S_IDLE;
        end else begin
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        l_we = 1'b1;
        if (rd_sc >= sc_q) begin
          // found slot: write new move at pos_q
          l_wmv = req_q.move_word; l_wsc = sc_q;
          cnt_d = cnt_q + CW'(1);
          state_d = S_IDLE;
        end else begin
          pos_d = pos_q - CW'(1);
          state_d = S_SHRD;
        end
      end
      S_RRD: begin
        l_ra = rpos_q[LA-1:0];
        state_d = S_ROUT;
      end
      S_ROUT: begin
        rv_d = 1'b1;
        if (rpos_q < cnt_q) begin
          rsp_d.ordered_move = rd_mv;
          rsp_d.move_priority = rd_sc;
          rsp_d.is_last = (rpos_q + CW'(1) == cnt_q);
          rsp_d.list_empty = 1'b0;
          rpos_d = rpos_q + CW'(1);
        end else begin
          rsp_d = '0;
          rsp_d.list_empty = 1'b1;
        end
        state_d = S_IDLE;
      end
      S_CRD: begin
        state_d = quiet ? S_CWR : S_IDLE;
      end
      S_CWR: begin
        h_we = 1'b1; h_w = rd_h + inc_q;
        if (rd_k1 != req_q.move_word) begin
          k_we = 1'b1; k_w1 = req_q.move_word; k_w2 = rd_k1;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
    // the search and its first read share one state entry
    if (state_q == S_LSC) l_ra = '0;
    if (state_q == S_SRCH) l_ra = pos_q[LA-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      cnt_q <= '0; rpos_q <= '0; pos_q <= '0;
      rv_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      cnt_q <= cnt_d; rpos_q <= rpos_d; pos_q <= pos_d;
      rv_q <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) req_q <= req_i;
    sc_q <= sc_d;
    part_q <= part_d;
    rsp_q <= rsp_d;
  end

  assign busy_o = (state_q != S_IDLE);
  assign rsp_valid_o = rv_q;
  assign rsp_o = rsp_q;

endmodule

// ===== rtl/kho_checker.sv =====
// ----------------------------------------------------------------------------
// kho_checker
// Port-level checks of the move orderer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kho_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input kho_pkg::req_t req_i,
  input logic          busy_o,
  input logic          rsp_valid_o,
  input kho_pkg::rsp_t rsp_o
);
  import kho_pkg::*;

  // accepted transaction makes the block busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("not busy after accept");

  // a result is never shown while idle in the cycle before
  a_rsp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(busy_o)) else $error("result without work");

  // empty read carries no move
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.list_empty |-> rsp_o.ordered_move == '0 && !rsp_o.is_last)
    else $error("empty read with payload");

  // results are single cycle strobes
  a_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |=> !rsp_valid_o) else $error("result held");

endmodule

bind killer_history_move_orderer kho_checker u_kho_checker (.*);
